// ===== rtl/gwrs_pkg.sv =====
// shared types and constants of the grid wavefront route search
package gwrs_pkg;

    localparam int DIST_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;
    localparam int FIELD_W   = 6;

    localparam logic [DIST_W-1:0]    DIST_NONE = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;

    localparam logic ACT_WRITE = 1'b0;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } t_dir;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SEED,
        S_SW_RD,
        S_SW_EV,
        S_NB,
        S_NB_EV,
        S_LVL,
        S_CHK,
        S_CHK_EV,
        S_TR_CHK,
        S_TR_NB,
        S_TR_EV,
        S_NR_RD,
        S_NR_EV,
        S_OUT
    } t_state;

endpackage

// ===== rtl/grid_wavefront_route_search.sv =====
// top level of the grid wavefront route search
// After reset the block clears all MAX_ROWS*MAX_COLS cells of the passability store and
// takes no request meanwhile; configuration writes are taken at all times. A query with
// start equal to destination skips the search and goes straight to the output state.
// Any other query runs on one distance memory and one passability memory, each read one
// address per cycle through a registered port: first the used N = rows*cols cells are
// marked unvisited, then for every wavefront level L from zero to the longest route length
// a sweep over the N cells reads, for each level-L cell, each neighbor inside the grid and
// skips each direction off the grid, then either a trace back that checks up to four
// neighbors per route step or a nearest-cell sweep over the N cells.
module grid_wavefront_route_search #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gwrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gwrs_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic [gwrs_pkg::FIELD_W-1:0]        i_cell_row,
    input  logic [gwrs_pkg::FIELD_W-1:0]        i_cell_col,
    input  logic                                i_cell_passable,
    input  logic [gwrs_pkg::FIELD_W-1:0]        i_start_row,
    input  logic [gwrs_pkg::FIELD_W-1:0]        i_start_col,
    input  logic [gwrs_pkg::FIELD_W-1:0]        i_dest_row,
    input  logic [gwrs_pkg::FIELD_W-1:0]        i_dest_col,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [gwrs_pkg::FIELD_W-1:0]        o_result_row,
    output logic [gwrs_pkg::FIELD_W-1:0]        o_result_col,
    output logic                                o_reached
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int XW    = $clog2(MAXD + 1);
    localparam int DW    = gwrs_pkg::DIST_W;
    localparam int FW    = gwrs_pkg::FIELD_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] r, input logic [XW-1:0] c);
        return AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
    endfunction

    function automatic logic [XW-1:0] clamp(input logic [FW-1:0] v, input logic [XW-1:0] n);
        if (9'(v) >= 9'(n)) begin
            return n - 1'b1;
        end else begin
            return XW'(v);
        end
    endfunction

    function automatic logic [XW-1:0] absdiff(input logic [XW-1:0] a, input logic [XW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [XW:0] manh(input logic [XW-1:0] ar, input logic [XW-1:0] ac,
                                         input logic [XW-1:0] br, input logic [XW-1:0] bc);
        return {1'b0, absdiff(ar, br)} + {1'b0, absdiff(ac, bc)};
    endfunction

    function automatic logic [XW-1:0] eff(input logic [gwrs_pkg::CFG_W-1:0] v, input int mx);
        if (v == '0) begin
            return XW'(1);
        end else if (9'(v) > 9'(mx)) begin
            return XW'(mx);
        end else begin
            return XW'(v);
        end
    endfunction

    // memories
    logic            r_pass_mem [CELLS];
    logic [DW-1:0]   r_dist_mem [CELLS];
    logic            r_pass_rd;
    logic [DW-1:0]   r_dist_rd;

    logic            pass_we, pass_wd, dist_we;
    logic [AW-1:0]   pass_wa, dist_wa, rd_addr;
    logic [DW-1:0]   dist_wd;

    gwrs_pkg::t_state r_state, n_state;
    gwrs_pkg::t_dir   r_k, n_k;
    logic [AW-1:0]    r_init_addr, n_init_addr;
    logic [gwrs_pkg::CFG_W-1:0] r_rows_cfg, r_cols_cfg;
    logic [XW-1:0]    r_sr, n_sr, r_sc, n_sc, r_dr, n_dr, r_dc, n_dc;
    logic [XW-1:0]    r_nr, n_nr, r_nc, n_nc, r_r, n_r, r_c, n_c;
    logic [XW-1:0]    r_xr, n_xr, r_xc, n_xc, r_tr_r, n_tr_r, r_tr_c, n_tr_c;
    logic [XW-1:0]    r_best_r, n_best_r, r_best_c, n_best_c;
    logic [XW-1:0]    r_pend_r, n_pend_r, r_pend_c, n_pend_c;
    logic [XW:0]      r_best_d, n_best_d;
    logic [DW-1:0]    r_lvl, n_lvl;
    logic             r_any, n_any, r_pend_hit, n_pend_hit;
    logic             r_out_valid, n_out_valid, r_out_hit, n_out_hit;
    logic [FW-1:0]    r_out_row, n_out_row, r_out_col, n_out_col;

    logic             in_acc;
    logic [XW-1:0]    q_nr, q_nc, q_sr, q_sc, q_dr, q_dc;
    logic [XW-1:0]    br, bc, nb_r, nb_c;
    logic             nb_ok, last_c, last_r;
    logic [XW:0]      cur_d;

    always_ff @(posedge i_clk) begin
        if (pass_we) begin
            r_pass_mem[pass_wa] <= pass_wd;
        end
        if (dist_we) begin
            r_dist_mem[dist_wa] <= dist_wd;
        end
        r_pass_rd <= r_pass_mem[rd_addr];
        r_dist_rd <= r_dist_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= gwrs_pkg::CFG_W'(1);
            r_cols_cfg <= gwrs_pkg::CFG_W'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == gwrs_pkg::CFG_ROWS) begin
                r_rows_cfg <= i_cfg_data;
            end else if (i_cfg_index == gwrs_pkg::CFG_COLS) begin
                r_cols_cfg <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == gwrs_pkg::S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_result_row = r_out_row;
    assign o_result_col = r_out_col;
    assign o_reached    = r_out_hit;

    assign q_nr = eff(r_rows_cfg, MAX_ROWS);
    assign q_nc = eff(r_cols_cfg, MAX_COLS);
    assign q_sr = clamp(i_start_row, q_nr);
    assign q_sc = clamp(i_start_col, q_nc);
    assign q_dr = clamp(i_dest_row, q_nr);
    assign q_dc = clamp(i_dest_col, q_nc);

    assign last_c = (r_c == r_nc - 1'b1);
    assign last_r = (r_r == r_nr - 1'b1);
    assign cur_d  = manh(r_r, r_c, r_dr, r_dc);

    // neighbor of the sweep cell or of the trace cell
    always_comb begin
        if (r_state == gwrs_pkg::S_TR_NB) begin
            br = r_tr_r;
            bc = r_tr_c;
        end else begin
            br = r_r;
            bc = r_c;
        end
        nb_r  = br;
        nb_c  = bc;
        nb_ok = 1'b0;
        case (r_k)
            gwrs_pkg::DIR_UP: begin
                nb_ok = (br != '0);
                nb_r  = br - 1'b1;
            end
            gwrs_pkg::DIR_DOWN: begin
                nb_ok = ({1'b0, br} + 1'b1) < {1'b0, r_nr};
                nb_r  = br + 1'b1;
            end
            gwrs_pkg::DIR_LEFT: begin
                nb_ok = (bc != '0);
                nb_c  = bc - 1'b1;
            end
            gwrs_pkg::DIR_RIGHT: begin
                nb_ok = ({1'b0, bc} + 1'b1) < {1'b0, r_nc};
                nb_c  = bc + 1'b1;
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_init_addr = r_init_addr;
        n_sr = r_sr; n_sc = r_sc; n_dr = r_dr; n_dc = r_dc;
        n_nr = r_nr; n_nc = r_nc; n_r = r_r; n_c = r_c;
        n_xr = r_xr; n_xc = r_xc; n_tr_r = r_tr_r; n_tr_c = r_tr_c;
        n_best_r = r_best_r; n_best_c = r_best_c; n_best_d = r_best_d;
        n_pend_r = r_pend_r; n_pend_c = r_pend_c; n_pend_hit = r_pend_hit;
        n_lvl = r_lvl; n_any = r_any;
        n_out_valid = r_out_valid; n_out_row = r_out_row;
        n_out_col = r_out_col; n_out_hit = r_out_hit;
        pass_we = 1'b0; pass_wa = r_init_addr; pass_wd = 1'b0;
        dist_we = 1'b0; dist_wa = cell_addr(r_r, r_c); dist_wd = gwrs_pkg::DIST_NONE;
        rd_addr = cell_addr(r_r, r_c);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            gwrs_pkg::S_INIT: begin
                pass_we     = 1'b1;
                n_init_addr = r_init_addr + 1'b1;
                if (r_init_addr == LAST_ADDR) begin
                    n_state = gwrs_pkg::S_IDLE;
                end
            end
            gwrs_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_action == gwrs_pkg::ACT_WRITE) begin
                        pass_we = (9'(i_cell_row) < 9'(MAX_ROWS)) &&
                                  (9'(i_cell_col) < 9'(MAX_COLS));
                        pass_wa = cell_addr(XW'(i_cell_row), XW'(i_cell_col));
                        pass_wd = i_cell_passable;
                    end else begin
                        n_nr = q_nr; n_nc = q_nc;
                        n_sr = q_sr; n_sc = q_sc; n_dr = q_dr; n_dc = q_dc;
                        n_r  = '0;   n_c  = '0;
                        if (q_sr == q_dr && q_sc == q_dc) begin
                            n_pend_r   = q_dr;
                            n_pend_c   = q_dc;
                            n_pend_hit = 1'b1;
                            n_state    = gwrs_pkg::S_OUT;
                        end else begin
                            n_state = gwrs_pkg::S_CLEAR;
                        end
                    end
                end
            end
            gwrs_pkg::S_CLEAR: begin
                dist_we = 1'b1;
                if (last_c) begin
                    n_c = '0;
                    n_r = r_r + 1'b1;
                    if (last_r) begin
                        n_state = gwrs_pkg::S_SEED;
                    end
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            gwrs_pkg::S_SEED: begin
                dist_we = 1'b1;
                dist_wa = cell_addr(r_sr, r_sc);
                dist_wd = '0;
                n_lvl   = '0;
                n_any   = 1'b0;
                n_r     = '0;
                n_c     = '0;
                n_state = gwrs_pkg::S_SW_RD;
            end
            gwrs_pkg::S_SW_RD: begin
                n_state = gwrs_pkg::S_SW_EV;
            end
            gwrs_pkg::S_SW_EV: begin
                if (r_dist_rd == r_lvl) begin
                    n_k     = gwrs_pkg::DIR_UP;
                    n_state = gwrs_pkg::S_NB;
                end else if (last_c) begin
                    n_c     = '0;
                    n_r     = r_r + 1'b1;
                    n_state = last_r ? gwrs_pkg::S_LVL : gwrs_pkg::S_SW_RD;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = gwrs_pkg::S_SW_RD;
                end
            end
            gwrs_pkg::S_NB, gwrs_pkg::S_NB_EV: begin
                if (r_state == gwrs_pkg::S_NB && nb_ok) begin
                    rd_addr = cell_addr(nb_r, nb_c);
                    n_xr    = nb_r;
                    n_xc    = nb_c;
                    n_state = gwrs_pkg::S_NB_EV;
                end else begin
                    if (r_state == gwrs_pkg::S_NB_EV && r_dist_rd == gwrs_pkg::DIST_NONE &&
                        r_pass_rd) begin
                        dist_we = 1'b1;
                        dist_wa = cell_addr(r_xr, r_xc);
                        dist_wd = r_lvl + 1'b1;
                        n_any   = 1'b1;
                    end
                    if (r_k == gwrs_pkg::DIR_RIGHT) begin
                        if (last_c) begin
                            n_c     = '0;
                            n_r     = r_r + 1'b1;
                            n_state = last_r ? gwrs_pkg::S_LVL : gwrs_pkg::S_SW_RD;
                        end else begin
                            n_c     = r_c + 1'b1;
                            n_state = gwrs_pkg::S_SW_RD;
                        end
                    end else begin
                        n_k     = gwrs_pkg::t_dir'(r_k + 1'b1);
                        n_state = gwrs_pkg::S_NB;
                    end
                end
            end
            gwrs_pkg::S_LVL: begin
                n_r = '0;
                n_c = '0;
                if (r_any) begin
                    n_lvl   = r_lvl + 1'b1;
                    n_any   = 1'b0;
                    n_state = gwrs_pkg::S_SW_RD;
                end else begin
                    n_state = gwrs_pkg::S_CHK;
                end
            end
            gwrs_pkg::S_CHK: begin
                rd_addr = cell_addr(r_dr, r_dc);
                n_state = gwrs_pkg::S_CHK_EV;
            end
            gwrs_pkg::S_CHK_EV: begin
                if (r_dist_rd != gwrs_pkg::DIST_NONE) begin
                    n_tr_r  = r_dr;
                    n_tr_c  = r_dc;
                    n_lvl   = r_dist_rd;
                    n_state = gwrs_pkg::S_TR_CHK;
                end else begin
                    n_best_r = r_sr;
                    n_best_c = r_sc;
                    n_best_d = manh(r_sr, r_sc, r_dr, r_dc);
                    n_state  = gwrs_pkg::S_NR_RD;
                end
            end
            gwrs_pkg::S_TR_CHK: begin
                n_k = gwrs_pkg::DIR_UP;
                if (r_lvl <= DW'(1)) begin
                    n_pend_r   = r_tr_r;
                    n_pend_c   = r_tr_c;
                    n_pend_hit = 1'b1;
                    n_state    = gwrs_pkg::S_OUT;
                end else begin
                    n_state = gwrs_pkg::S_TR_NB;
                end
            end
            gwrs_pkg::S_TR_NB, gwrs_pkg::S_TR_EV: begin
                if (r_state == gwrs_pkg::S_TR_NB && nb_ok) begin
                    rd_addr = cell_addr(nb_r, nb_c);
                    n_xr    = nb_r;
                    n_xc    = nb_c;
                    n_state = gwrs_pkg::S_TR_EV;
                end else if (r_state == gwrs_pkg::S_TR_EV && r_dist_rd == r_lvl - 1'b1) begin
                    n_tr_r  = r_xr;
                    n_tr_c  = r_xc;
                    n_lvl   = r_lvl - 1'b1;
                    n_state = gwrs_pkg::S_TR_CHK;
                end else if (r_k == gwrs_pkg::DIR_RIGHT) begin
                    n_pend_r   = r_tr_r;
                    n_pend_c   = r_tr_c;
                    n_pend_hit = 1'b1;
                    n_state    = gwrs_pkg::S_OUT;
                end else begin
                    n_k     = gwrs_pkg::t_dir'(r_k + 1'b1);
                    n_state = gwrs_pkg::S_TR_NB;
                end
            end
            gwrs_pkg::S_NR_RD: begin
                n_state = gwrs_pkg::S_NR_EV;
            end
            gwrs_pkg::S_NR_EV: begin
                if (r_dist_rd != gwrs_pkg::DIST_NONE && cur_d < r_best_d) begin
                    n_best_r = r_r;
                    n_best_c = r_c;
                    n_best_d = cur_d;
                end
                n_state = gwrs_pkg::S_NR_RD;
                if (last_c) begin
                    n_c = '0;
                    n_r = r_r + 1'b1;
                    if (last_r) begin
                        n_pend_r   = (r_dist_rd != gwrs_pkg::DIST_NONE && cur_d < r_best_d)
                                     ? r_r : r_best_r;
                        n_pend_c   = (r_dist_rd != gwrs_pkg::DIST_NONE && cur_d < r_best_d)
                                     ? r_c : r_best_c;
                        n_pend_hit = 1'b0;
                        n_state    = gwrs_pkg::S_OUT;
                    end
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            gwrs_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_row   = FW'(r_pend_r);
                    n_out_col   = FW'(r_pend_c);
                    n_out_hit   = r_pend_hit;
                    n_state     = gwrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gwrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gwrs_pkg::S_INIT;
            r_init_addr <= '0;
            r_out_valid <= 1'b0;
            r_k         <= gwrs_pkg::DIR_UP;
            r_any       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_any       <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr <= n_sr; r_sc <= n_sc; r_dr <= n_dr; r_dc <= n_dc;
        r_nr <= n_nr; r_nc <= n_nc; r_r <= n_r; r_c <= n_c;
        r_xr <= n_xr; r_xc <= n_xc; r_tr_r <= n_tr_r; r_tr_c <= n_tr_c;
        r_best_r <= n_best_r; r_best_c <= n_best_c; r_best_d <= n_best_d;
        r_pend_r <= n_pend_r; r_pend_c <= n_pend_c; r_pend_hit <= n_pend_hit;
        r_lvl <= n_lvl;
        r_out_row <= n_out_row; r_out_col <= n_out_col; r_out_hit <= n_out_hit;
    end

`ifndef SYNTH
    a_no_dist_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gwrs_pkg::S_IDLE) |-> !dist_we)
        else $error("distance store written while idle");

    a_trace_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gwrs_pkg::S_TR_EV) |-> (r_lvl > DW'(1)))
        else $error("trace back below level one");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == gwrs_pkg::S_OUT))
        else $error("result loaded outside output state");
`endif

endmodule
